// ===== hw/rtl/rhs_pkg.sv =====
// Shared types and constants for the RTP header stripper.
// Used by rhs_parser, rhs_emitter and rtp_header_stripper; depends on nothing.
`default_nettype none

package rhs_pkg;

  // Fixed RTP header length in bytes and the field masks of byte 0.
  localparam int unsigned FixedHdrLen = 12;
  localparam logic [7:0]  CsrcMask    = 8'h0F;
  localparam logic [7:0]  ExtMask     = 8'h10;

  // Widths of the packet position counters.
  localparam int unsigned PosW = 19;

  // Most results that one item can cause (a short packet of 11 bytes).
  localparam int unsigned MaxResults = 11;
  localparam int unsigned CntW       = 4;

  // Result kinds.
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindShort   = 2'd1;
  localparam logic [1:0] KindEmpty   = 2'd2;

  // Parse phases of a packet.
  typedef enum logic [2:0] {
    PhFixed   = 3'd0,
    PhSkip    = 3'd1,
    PhExtWord = 3'd2,
    PhExtNext = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  // Input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } rhs_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] out_kind;
  } rhs_out_t;

  // All results caused by one item, handed from the parser to the emitter.
  typedef struct packed {
    logic [CntW-1:0]                 cnt;
    logic [1:0]                      kind;
    logic                            fin_last;
    logic [MaxResults-1:0][7:0]      bytes;
  } rhs_burst_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtp_header_stripper.sv =====
// RTP header stripper top level: input register, parser and result emitter.
// Depends on rhs_pkg, rhs_parser and rhs_emitter.
//
// Usage: packet bytes enter on the input channel (in_valid_i, in_item_i,
// in_stall_o), one byte per item with in_last on the final byte. Only the
// payload leaves on the output channel (out_valid_o, out_item_o,
// out_stall_i). A packet shorter than 12 bytes is sent out whole as raw
// bytes; a packet with nothing past its header yields one empty-packet
// marker item.
// Path: an accepted item waits in the input register, is parsed there
// combinationally, and its first result is loaded into the output register.
// Throughput: one item per cycle while the output is not stalled. An item
// that causes N results (at most 11, on the last byte of a short packet, or
// up to 4 for a cut-off header extension word) holds the input while the
// emitter's single output register drains them from its shift buffer.
// Reset clears the input and output valids and starts a new packet.
// When the receiver stalls, the output item holds and the input register
// keeps one further item before in_stall_o rises.
`default_nettype none

module rtp_header_stripper (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rhs_pkg::rhs_in_t   in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rhs_pkg::rhs_out_t       out_item_o
);

  logic                  in_full_q, in_full_d;
  rhs_pkg::rhs_in_t      in_item_q;
  logic                  emit_ready;
  logic                  fire;
  logic                  in_take;
  rhs_pkg::rhs_burst_t   burst;

  assign fire       = in_full_q && emit_ready;
  assign in_stall_o = in_full_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_full_d  = in_take || (in_full_q && !fire);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  // Header parsing of the registered item.
  rhs_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_item_q),
    .fire_i  (fire),
    .burst_o (burst)
  );

  // Result output.
  rhs_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .load_i      (fire),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rhs_parser.sv =====
// Header parser: phase state machine, packet position and held header bytes.
// Depends on rhs_pkg; turns one registered input item into a burst of results.
`default_nettype none

module rhs_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rhs_pkg::rhs_in_t   item_i,
  input  wire logic               fire_i,
  output rhs_pkg::rhs_burst_t     burst_o
);

  rhs_pkg::phase_e                 phase_q, phase_d;
  logic [rhs_pkg::PosW-1:0]        pos_q, pos_d;
  logic [rhs_pkg::PosW-1:0]        hdr_q, hdr_d;
  logic                            ext_q, ext_d;
  logic [11:0][7:0]                held_q;

  logic                            held_we;
  logic [3:0]                      held_idx;
  logic [3:0]                      fix_k;
  logic [1:0]                      ext_k;
  logic [15:0]                     ext_len;
  logic                            restart;
  logic                            use_one;
  logic [7:0]                      one_byte;
  logic [7:0]                      b;
  logic                            last;

  assign b       = item_i.in_byte;
  assign last    = item_i.in_last;
  assign fix_k   = (pos_q > rhs_pkg::PosW'(11)) ? 4'd11 : pos_q[3:0];
  assign ext_k   = pos_q[1:0] - hdr_q[1:0];
  assign ext_len = {held_q[2], held_q[3]};

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rhs_pkg::PhFixed;
      pos_q   <= '0;
      hdr_q   <= rhs_pkg::PosW'(rhs_pkg::FixedHdrLen);
      ext_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      ext_q   <= ext_d;
    end
  end

  // Held bytes: header start, later the extension word. No reset needed.
  always_ff @(posedge clk_i) begin
    if (fire_i && held_we) begin
      held_q[held_idx] <= b;
    end
  end

  // Next state and the results of the current item.
  always_comb begin
    phase_d          = phase_q;
    pos_d            = pos_q;
    hdr_d            = hdr_q;
    ext_d            = ext_q;
    held_we          = 1'b0;
    held_idx         = fix_k;
    restart          = 1'b0;
    use_one          = 1'b0;
    one_byte         = 8'h00;
    burst_o.cnt      = '0;
    burst_o.kind     = rhs_pkg::KindPayload;
    burst_o.fin_last = 1'b1;

    unique case (phase_q)
      rhs_pkg::PhSkip: begin
        if (last) begin
          burst_o.cnt  = rhs_pkg::CntW'(1);
          burst_o.kind = rhs_pkg::KindEmpty;
          use_one      = 1'b1;
          restart      = 1'b1;
        end else begin
          if ((pos_q + rhs_pkg::PosW'(1)) >= hdr_q) begin
            phase_d = ext_q ? rhs_pkg::PhExtWord : rhs_pkg::PhPayload;
          end
          pos_d = pos_q + rhs_pkg::PosW'(1);
        end
      end

      rhs_pkg::PhExtWord: begin
        held_we  = 1'b1;
        held_idx = {2'b00, ext_k};
        if (last) begin
          // Extension word cut short: its bytes so far are payload.
          burst_o.cnt = rhs_pkg::CntW'(ext_k) + rhs_pkg::CntW'(1);
          restart     = 1'b1;
        end else begin
          if (ext_k == 2'd3) begin
            phase_d = rhs_pkg::PhExtNext;
          end
          pos_d = pos_q + rhs_pkg::PosW'(1);
        end
      end

      rhs_pkg::PhExtNext: begin
        hdr_d = hdr_q + rhs_pkg::PosW'(4) + {1'b0, ext_len, 2'b00};
        ext_d = 1'b0;
        if (ext_len == 16'd0) begin
          burst_o.cnt      = rhs_pkg::CntW'(1);
          burst_o.fin_last = last;
          use_one          = 1'b1;
          one_byte         = b;
          if (last) begin
            restart = 1'b1;
          end else begin
            phase_d = rhs_pkg::PhPayload;
          end
        end else if (last) begin
          burst_o.cnt  = rhs_pkg::CntW'(1);
          burst_o.kind = rhs_pkg::KindEmpty;
          use_one      = 1'b1;
          restart      = 1'b1;
        end else begin
          phase_d = rhs_pkg::PhSkip;
          pos_d   = pos_q + rhs_pkg::PosW'(1);
        end
      end

      rhs_pkg::PhPayload: begin
        burst_o.cnt      = rhs_pkg::CntW'(1);
        burst_o.fin_last = last;
        use_one          = 1'b1;
        one_byte         = b;
        restart          = last;
      end

      default: begin
        // Fixed header phase; unused phase codes behave the same way.
        held_we = 1'b1;
        if (last) begin
          if (fix_k < 4'd11) begin
            burst_o.cnt  = fix_k + rhs_pkg::CntW'(1);
            burst_o.kind = rhs_pkg::KindShort;
          end else begin
            burst_o.cnt  = rhs_pkg::CntW'(1);
            burst_o.kind = rhs_pkg::KindEmpty;
            use_one      = 1'b1;
          end
          restart = 1'b1;
        end else begin
          if (fix_k == 4'd11) begin
            hdr_d = rhs_pkg::PosW'(rhs_pkg::FixedHdrLen)
                  + {13'd0, held_q[0][3:0] & rhs_pkg::CsrcMask[3:0], 2'b00};
            ext_d = ((held_q[0] & rhs_pkg::ExtMask) != 8'h00);
            if ((held_q[0] & rhs_pkg::CsrcMask) != 8'h00) begin
              phase_d = rhs_pkg::PhSkip;
            end else if ((held_q[0] & rhs_pkg::ExtMask) != 8'h00) begin
              phase_d = rhs_pkg::PhExtWord;
            end else begin
              phase_d = rhs_pkg::PhPayload;
            end
          end
          pos_d = rhs_pkg::PosW'(fix_k) + rhs_pkg::PosW'(1);
        end
      end
    endcase

    // Every piece of packet state returns to its reset value after a last byte.
    if (restart) begin
      phase_d = rhs_pkg::PhFixed;
      pos_d   = '0;
      hdr_d   = rhs_pkg::PosW'(rhs_pkg::FixedHdrLen);
      ext_d   = 1'b0;
    end

    // Result bytes: a single byte, or the held bytes with the current one merged in.
    for (int i = 0; i < rhs_pkg::MaxResults; i++) begin
      if (use_one) begin
        burst_o.bytes[i] = (i == 0) ? one_byte : 8'h00;
      end else begin
        burst_o.bytes[i] = (4'(i) == held_idx) ? b : held_q[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rhs_emitter.sv =====
// Result emitter: output register plus a shift buffer for multi-result bursts.
// Depends on rhs_pkg; takes bursts from rhs_parser and presents one item per cycle while not stalled.
`default_nettype none

module rhs_emitter (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rhs_pkg::rhs_burst_t burst_i,
  input  wire logic                load_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rhs_pkg::rhs_out_t        out_item_o
);

  localparam int unsigned BufN = rhs_pkg::MaxResults - 1;

  logic                            out_valid_q, out_valid_d;
  rhs_pkg::rhs_out_t               out_item_q, out_item_d;
  logic [rhs_pkg::CntW-1:0]        pend_q, pend_d;
  logic [BufN-1:0][7:0]            buf_q, buf_d;
  logic [1:0]                      kind_q, kind_d;
  logic                            fin_q, fin_d;
  logic                            take;

  assign take        = out_valid_q && !out_stall_i;
  assign ready_o     = (pend_q == '0) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    buf_q      <= buf_d;
    kind_q     <= kind_d;
    fin_q      <= fin_d;
  end

  // Drain the buffer first; a new burst is only loaded once it is empty.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    pend_d      = pend_q;
    buf_d       = buf_q;
    kind_d      = kind_q;
    fin_d       = fin_q;
    if ((pend_q != '0) && (!out_valid_q || take)) begin
      out_valid_d         = 1'b1;
      out_item_d.out_byte = buf_q[0];
      out_item_d.out_last = (pend_q == rhs_pkg::CntW'(1)) && fin_q;
      out_item_d.out_kind = kind_q;
      for (int i = 0; i < BufN - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      pend_d = pend_q - rhs_pkg::CntW'(1);
    end else if (load_i && (burst_i.cnt != '0)) begin
      out_valid_d         = 1'b1;
      out_item_d.out_byte = burst_i.bytes[0];
      out_item_d.out_last = (burst_i.cnt == rhs_pkg::CntW'(1)) && burst_i.fin_last;
      out_item_d.out_kind = burst_i.kind;
      for (int i = 0; i < BufN; i++) begin
        buf_d[i] = burst_i.bytes[i+1];
      end
      pend_d = burst_i.cnt - rhs_pkg::CntW'(1);
      kind_d = burst_i.kind;
      fin_d  = burst_i.fin_last;
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/rtp_header_stripper_tb.sv =====
// Self-checking testbench for rtp_header_stripper: random RTP packets go in,
// the stripped payload is predicted in the bench and compared item by item.
// Depends on rhs_pkg and the rtp_header_stripper RTL only.
module rtp_header_stripper_tb;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rhs_pkg::rhs_in_t  in_item;
  logic              out_valid;
  logic              out_stall;
  rhs_pkg::rhs_out_t out_item;

  // Stimulus and scoreboard storage.
  rhs_pkg::rhs_in_t  src_q[$];
  rhs_pkg::rhs_out_t stripped_q[$];
  logic     in_fire;
  int       send_idle_pct;
  int       stall_pct;
  int       mismatch_cnt;

  // Packet parser state kept by the bench.
  logic [rhs_pkg::PosW-1:0] sp_pos;
  logic [rhs_pkg::PosW-1:0] sp_hdr_end;
  rhs_pkg::phase_e          sp_phase;
  logic [7:0]               sp_held [12];
  logic                     sp_ext_pending;

  rtp_header_stripper u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // Clock with a period of 8.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // Bring the bench parser back to the start of a packet.
  task automatic start_packet();
    sp_pos         = '0;
    sp_hdr_end     = rhs_pkg::PosW'(rhs_pkg::FixedHdrLen);
    sp_phase       = rhs_pkg::PhFixed;
    sp_ext_pending = 1'b0;
  endtask

  task automatic expect_item(input logic [7:0] b, input logic last, input logic [1:0] kind);
    rhs_pkg::rhs_out_t r;
    r.out_byte = b;
    r.out_last = last;
    r.out_kind = kind;
    stripped_q.push_back(r);
  endtask

  // A packet with nothing past its header yields a single marker item.
  task automatic expect_empty_marker();
    expect_item(8'h00, 1'b1, rhs_pkg::KindEmpty);
    start_packet();
  endtask

  // Work out the results that one accepted packet byte causes.
  task automatic strip_step(input rhs_pkg::rhs_in_t it);
    int unsigned k;
    int unsigned i;
    logic [15:0] ext_words;
    case (sp_phase)
      rhs_pkg::PhSkip: begin
        if (it.in_last) begin
          expect_empty_marker();
        end else begin
          if (sp_pos + 1 >= sp_hdr_end) begin
            sp_phase = sp_ext_pending ? rhs_pkg::PhExtWord : rhs_pkg::PhPayload;
          end
          sp_pos++;
        end
      end
      rhs_pkg::PhExtWord: begin
        k = (sp_pos - sp_hdr_end) & 3;
        sp_held[k] = it.in_byte;
        if (it.in_last) begin
          // The extension word was cut off: its bytes so far are payload.
          for (i = 0; i <= k; i++) expect_item(sp_held[i], i == k, rhs_pkg::KindPayload);
          start_packet();
        end else begin
          if (k == 3) sp_phase = rhs_pkg::PhExtNext;
          sp_pos++;
        end
      end
      rhs_pkg::PhExtNext: begin
        ext_words      = {sp_held[2], sp_held[3]};
        sp_hdr_end     = sp_hdr_end + 4 + 4 * ext_words;
        sp_ext_pending = 1'b0;
        if (ext_words == 16'd0) begin
          expect_item(it.in_byte, it.in_last, rhs_pkg::KindPayload);
          if (it.in_last) start_packet();
          else sp_phase = rhs_pkg::PhPayload;
        end else if (it.in_last) begin
          expect_empty_marker();
        end else begin
          sp_phase = rhs_pkg::PhSkip;
          sp_pos++;
        end
      end
      rhs_pkg::PhPayload: begin
        expect_item(it.in_byte, it.in_last, rhs_pkg::KindPayload);
        if (it.in_last) start_packet();
      end
      default: begin
        // Fixed header; any unused phase code behaves the same.
        k = (sp_pos > 11) ? 11 : sp_pos;
        sp_held[k] = it.in_byte;
        if (it.in_last) begin
          if (k < 11) begin
            for (i = 0; i <= k; i++) expect_item(sp_held[i], i == k, rhs_pkg::KindShort);
            start_packet();
          end else begin
            expect_empty_marker();
          end
        end else begin
          if (k == 11) begin
            sp_hdr_end     = rhs_pkg::PosW'(rhs_pkg::FixedHdrLen)
                           + 4 * (sp_held[0] & rhs_pkg::CsrcMask);
            sp_ext_pending = |(sp_held[0] & rhs_pkg::ExtMask);
            if (sp_hdr_end > rhs_pkg::FixedHdrLen) sp_phase = rhs_pkg::PhSkip;
            else sp_phase = sp_ext_pending ? rhs_pkg::PhExtWord : rhs_pkg::PhPayload;
          end
          sp_pos = k + 1;
        end
      end
    endcase
  endtask

  // Queue one packet: byte 0 as given, the extension length in place when
  // the extension bit is set, everything else random.
  task automatic queue_packet(input logic [7:0] b0, input logic [15:0] ext_len,
                              input int unsigned len);
    int unsigned hdr;
    int unsigned i;
    rhs_pkg::rhs_in_t it;
    hdr = rhs_pkg::FixedHdrLen + 4 * (b0 & rhs_pkg::CsrcMask);
    for (i = 0; i < len; i++) begin
      it.in_byte = 8'($urandom_range(255));
      if (i == 0) it.in_byte = b0;
      else if ((b0 & rhs_pkg::ExtMask) != 0 && i == hdr + 2) it.in_byte = ext_len[15:8];
      else if ((b0 & rhs_pkg::ExtMask) != 0 && i == hdr + 3) it.in_byte = ext_len[7:0];
      it.in_last = (i == len - 1);
      src_q.push_back(it);
    end
  endtask

  // Input driver: a new item is offered once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (src_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= src_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check results first, then predict from the item accepted at this edge.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (stripped_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item byte %02h last %0d kind %0d",
                                    out_item.out_byte, out_item.out_last, out_item.out_kind));
        end else begin
          if (out_item.out_byte !== stripped_q[0].out_byte ||
              out_item.out_last !== stripped_q[0].out_last ||
              out_item.out_kind !== stripped_q[0].out_kind) begin
            report_mismatch($sformatf("got byte %02h last %0d kind %0d, want %02h %0d %0d",
                                      out_item.out_byte, out_item.out_last, out_item.out_kind,
                                      stripped_q[0].out_byte, stripped_q[0].out_last,
                                      stripped_q[0].out_kind));
          end
          void'(stripped_q.pop_front());
        end
      end
      if (in_valid && !in_stall) strip_step(in_item);
    end
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, stimulus phases and the end of the run.
  initial begin
    int unsigned ph;
    int unsigned n_items;
    int unsigned n_pkts;
    int unsigned cc;
    int unsigned hdr;
    int unsigned len;
    int unsigned ext_len;
    logic [7:0]  b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    out_stall     = 1'b0;
    in_fire       = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    mismatch_cnt  = 0;
    n_pkts        = 0;
    for (int j = 0; j < 12; j++) sp_held[j] = 8'h00;
    start_packet();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase

      if (ph == 0) begin
        // One-byte packet of all ones, the longest short packet, and a
        // packet that is exactly a bare fixed header.
        queue_packet(8'hFF, 16'd0, 1);
        queue_packet(8'h00, 16'd0, 11);
        queue_packet(8'h80, 16'd0, 12);
      end

      // Random packets, cycling through the packet shapes.
      n_items = 0;
      while (n_items < 20) begin
        cc  = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
        hdr = rhs_pkg::FixedHdrLen + 4 * cc;
        ext_len = 0;
        case (n_pkts % 7)
          0: begin
            // Short packet.
            b0  = 8'($urandom_range(255));
            len = $urandom_range(1, 11);
          end
          1: begin
            // Ends inside the CSRC list or right at the header end.
            b0  = {3'($urandom_range(7)), 1'b0, 4'(cc)};
            len = $urandom_range(12, hdr);
          end
          2: begin
            // Plain payload, now and then a long one.
            b0  = {3'($urandom_range(7)), 1'b0, 4'(cc)};
            len = hdr + (($urandom_range(5) == 0) ? 40 : $urandom_range(1, 16));
          end
          3: begin
            // Cut off within the extension word.
            b0      = {3'($urandom_range(7)), 1'b1, 4'(cc)};
            ext_len = $urandom_range(16'hFFFF);
            len     = hdr + $urandom_range(1, 4);
          end
          4: begin
            // Extension of zero length.
            b0  = {3'($urandom_range(7)), 1'b1, 4'(cc)};
            len = hdr + 4 + $urandom_range(1, 8);
          end
          5: begin
            // Extension data skipped; ends inside it or in the payload.
            b0      = {3'($urandom_range(7)), 1'b1, 4'(cc)};
            ext_len = $urandom_range(1, 3);
            len     = hdr + 4 + $urandom_range(1, 4 * ext_len + 8);
          end
          default: begin
            // Noise: random header fields and length.
            b0      = 8'($urandom_range(255));
            ext_len = $urandom_range(16'hFFFF);
            len     = $urandom_range(1, 30);
          end
        endcase
        queue_packet(b0, 16'(ext_len), len);
        n_items += len;
        n_pkts++;
      end

      while (src_q.size() != 0 || in_valid || stripped_q.size() != 0) @(negedge clk);
    end

    // Let any stray item come out before the verdict.
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && stripped_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
